// File: rtl/core/dsp_pkg.sv
// shared types and constants for the dense dijkstra shortest path block
// no dependencies
`default_nettype none
package dsp_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int VCNT_W       = VIDX_W + 1;
  localparam int WEIGHT_BITS  = 24;
  localparam int DIST_BITS    = 32;
  localparam int OUT_DIST_W   = 32;
  localparam int MAT_DEPTH    = MAX_VERTICES * MAX_VERTICES;
  localparam int MAT_AW       = $clog2(MAT_DEPTH);

  localparam logic [DIST_BITS-1:0] DIST_INF  = '1;
  localparam logic [VCNT_W-1:0]    NO_PARENT = VCNT_W'(MAX_VERTICES);
  localparam logic [VCNT_W-1:0]    VCNT_MIN  = VCNT_W'(2);
  localparam logic [VCNT_W-1:0]    VCNT_MAX  = VCNT_W'(MAX_VERTICES);

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // per-vertex working state kept in one memory word
  typedef struct packed {
    logic                 visited;
    logic [VCNT_W-1:0]    parent;
    logic [DIST_BITS-1:0] cost;
  } vstate_t;

  localparam int VST_W   = $bits(vstate_t);
  localparam int STACK_W = VIDX_W + DIST_BITS;

  // one result beat from the engine to the output register
  typedef struct packed {
    logic                  ld;
    logic [VIDX_W-1:0]     vertex;
    logic [OUT_DIST_W-1:0] distance;
    logic                  unreachable;
    logic                  last;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/core/dense_dijkstra_shortest_path.sv
// Dense-matrix shortest path engine. Edge write beats are taken while idle. A
// clear beat, and reset itself, sweep the 4096-entry weight memory one entry per
// cycle, so the input is stalled until the sweep ends. A query over n vertices
// (n = vertex_count clamped to 2..64) initialises n vertex state entries, then
// runs n-1 rounds of scan, mark and relax, where scan and relax both walk the
// single read port of the vertex state memory, then traces the path onto a
// stack and emits one result beat per path vertex.
// depends on dsp_pkg and dsp_engine
`default_nettype none
module dense_dijkstra_shortest_path
  import dsp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input item channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             in_action,
  input  wire logic [VIDX_W-1:0]      in_from_vertex,
  input  wire logic [VIDX_W-1:0]      in_to_vertex,
  input  wire logic [WEIGHT_BITS-1:0] in_edge_weight_in,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [VIDX_W-1:0]           out_path_vertex,
  output logic [OUT_DIST_W-1:0]       out_path_distance,
  output logic                        out_unreachable,
  output logic                        out_last,
  // vertex_count register write
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [VCNT_W-1:0]      cfg_data
);

  logic [VCNT_W-1:0]     vcount_r;
  logic [VCNT_W-1:0]     n_active;
  logic                  out_valid_r;
  logic [VIDX_W-1:0]     vertex_r;
  logic [OUT_DIST_W-1:0] dist_r;
  logic                  unr_r;
  logic                  last_r;
  logic                  out_free;
  res_t                  res;

  // register is always writable
  assign cfg_ready = 1'b1;

  // clamp the vertex count into the supported range
  always_comb begin
    if (vcount_r < VCNT_MIN) begin
      n_active = VCNT_MIN;
    end else if (vcount_r > VCNT_MAX) begin
      n_active = VCNT_MAX;
    end else begin
      n_active = vcount_r;
    end
  end

  // the output register can take a beat when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  dsp_engine u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_from_vertex    (in_from_vertex),
    .in_to_vertex      (in_to_vertex),
    .in_edge_weight_in (in_edge_weight_in),
    .n_active          (n_active),
    .out_free          (out_free),
    .res               (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r    <= VCNT_MAX;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vcount_r <= cfg_data;
      end
      if (res.ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    // payload holds while a beat waits
    if (res.ld) begin
      vertex_r <= res.vertex;
      dist_r   <= res.distance;
      unr_r    <= res.unreachable;
      last_r   <= res.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_path_vertex   = vertex_r;
  assign out_path_distance = dist_r;
  assign out_unreachable   = unr_r;
  assign out_last          = last_r;

endmodule
`default_nettype wire

// File: rtl/core/dsp_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none
module dsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/dsp_engine.sv
// query sequencer: matrix, vertex state and path stack memories plus control
// depends on dsp_pkg and dsp_ram
`default_nettype none
module dsp_engine
  import dsp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             in_action,
  input  wire logic [VIDX_W-1:0]      in_from_vertex,
  input  wire logic [VIDX_W-1:0]      in_to_vertex,
  input  wire logic [WEIGHT_BITS-1:0] in_edge_weight_in,
  input  wire logic [VCNT_W-1:0]      n_active,
  input  wire logic                   out_free,
  output res_t                        res
);

  typedef enum logic [10:0] {
    S_CLEAR     = 11'b000_0000_0001,
    S_IDLE      = 11'b000_0000_0010,
    S_INIT      = 11'b000_0000_0100,
    S_SCAN      = 11'b000_0000_1000,
    S_MARK      = 11'b000_0001_0000,
    S_RELAX     = 11'b000_0010_0000,
    S_TRACE_RD  = 11'b000_0100_0000,
    S_TRACE_CHK = 11'b000_1000_0000,
    S_EMIT_RD   = 11'b001_0000_0000,
    S_EMIT_LD   = 11'b010_0000_0000,
    S_EMIT_UNR  = 11'b100_0000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic [MAT_AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic [VCNT_W-1:0]    cnt_r, cnt_nxt;
  logic [VCNT_W-1:0]    round_r, round_nxt;
  logic [VIDX_W-1:0]    src_r, src_nxt;
  logic [VIDX_W-1:0]    dst_r, dst_nxt;
  logic [VIDX_W-1:0]    u_r, u_nxt;
  vstate_t              best_r, best_nxt;
  logic [VIDX_W-1:0]    v_r, v_nxt;
  logic [VCNT_W-1:0]    depth_r, depth_nxt;

  logic                   m_we;
  logic [MAT_AW-1:0]      m_waddr, m_raddr;
  logic [WEIGHT_BITS-1:0] m_wdata, m_rdata;
  logic                   v_we;
  logic [VIDX_W-1:0]      v_waddr, v_raddr;
  vstate_t                v_wdata, v_rdata;
  logic [VST_W-1:0]       v_rdata_raw;
  logic                   s_we;
  logic [VIDX_W-1:0]      s_waddr, s_raddr;
  logic [STACK_W-1:0]     s_wdata, s_rdata;

  logic                   accept;
  logic [VCNT_W-1:0]      cnt_m1;
  logic [VCNT_W-1:0]      depth_p1;
  logic [DIST_BITS:0]     sum;
  logic [DIST_BITS-1:0]   nd;

  assign v_rdata  = vstate_t'(v_rdata_raw);
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign cnt_m1   = cnt_r - VCNT_W'(1);
  assign depth_p1 = depth_r + VCNT_W'(1);
  assign sum      = {1'b0, best_r.cost} + (DIST_BITS+1)'(m_rdata);
  assign nd       = (sum >= (DIST_BITS+1)'(DIST_INF)) ? DIST_INF : sum[DIST_BITS-1:0];

  dsp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAT_DEPTH)) u_matrix (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  dsp_ram #(.WIDTH(VST_W), .DEPTH(MAX_VERTICES)) u_vstate (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata_raw)
  );

  dsp_ram #(.WIDTH(STACK_W), .DEPTH(MAX_VERTICES)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    cnt_nxt      = cnt_r;
    round_nxt    = round_r;
    src_nxt      = src_r;
    dst_nxt      = dst_r;
    u_nxt        = u_r;
    best_nxt     = best_r;
    v_nxt        = v_r;
    depth_nxt    = depth_r;
    m_we         = 1'b0;
    m_waddr      = clr_addr_r;
    m_wdata      = '0;
    m_raddr      = {u_r, cnt_r[VIDX_W-1:0]};
    v_we         = 1'b0;
    v_waddr      = cnt_r[VIDX_W-1:0];
    v_wdata      = '0;
    v_raddr      = cnt_r[VIDX_W-1:0];
    s_we         = 1'b0;
    s_waddr      = depth_r[VIDX_W-1:0];
    s_wdata      = {v_r, v_rdata.cost};
    s_raddr      = cnt_m1[VIDX_W-1:0];
    res          = '0;
    case (state_r)
      S_CLEAR: begin
        m_we         = 1'b1;
        clr_addr_nxt = clr_addr_r + MAT_AW'(1);
        if (clr_addr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (action_t'(in_action))
            ACT_WRITE: begin
              m_we    = 1'b1;
              m_waddr = {in_from_vertex, in_to_vertex};
              m_wdata = in_edge_weight_in;
            end
            ACT_QUERY: begin
              src_nxt = in_from_vertex;
              dst_nxt = in_to_vertex;
              cnt_nxt = '0;
              if (VCNT_W'(in_from_vertex) >= n_active ||
                  VCNT_W'(in_to_vertex) >= n_active) begin
                state_nxt = S_EMIT_UNR;
              end else begin
                state_nxt = S_INIT;
              end
            end
            ACT_CLEAR: begin
              clr_addr_nxt = '0;
              state_nxt    = S_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      S_INIT: begin
        v_we            = 1'b1;
        v_wdata.visited = 1'b0;
        v_wdata.parent  = NO_PARENT;
        v_wdata.cost    = (cnt_r[VIDX_W-1:0] == src_r) ? '0 : DIST_INF;
        cnt_nxt         = cnt_r + VCNT_W'(1);
        if (cnt_r == n_active - VCNT_W'(1)) begin
          cnt_nxt       = '0;
          round_nxt     = '0;
          best_nxt.cost = DIST_INF;
          u_nxt         = '0;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        // reads issued one per cycle, compared in the next cycle
        if (cnt_r != '0) begin
          if (!v_rdata.visited && v_rdata.cost <= best_r.cost) begin
            best_nxt = v_rdata;
            u_nxt    = cnt_m1[VIDX_W-1:0];
          end
        end
        cnt_nxt = cnt_r + VCNT_W'(1);
        if (cnt_r == n_active) begin
          state_nxt = S_MARK;
        end
      end
      S_MARK: begin
        v_we            = 1'b1;
        v_waddr         = u_r;
        v_wdata         = best_r;
        v_wdata.visited = 1'b1;
        cnt_nxt         = '0;
        state_nxt       = S_RELAX;
      end
      S_RELAX: begin
        // write-back of entry j overlaps the read of entry j+1
        if (cnt_r != '0) begin
          if (!v_rdata.visited && m_rdata != '0 && nd < v_rdata.cost) begin
            v_we            = 1'b1;
            v_waddr         = cnt_m1[VIDX_W-1:0];
            v_wdata.visited = 1'b0;
            v_wdata.parent  = {1'b0, u_r};
            v_wdata.cost    = nd;
          end
        end
        cnt_nxt = cnt_r + VCNT_W'(1);
        if (cnt_r == n_active) begin
          cnt_nxt   = '0;
          round_nxt = round_r + VCNT_W'(1);
          if (round_r + VCNT_W'(2) == n_active) begin
            v_nxt     = dst_r;
            depth_nxt = '0;
            state_nxt = S_TRACE_RD;
          end else begin
            best_nxt.cost = DIST_INF;
            u_nxt         = '0;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_TRACE_RD: begin
        v_raddr   = v_r;
        state_nxt = S_TRACE_CHK;
      end
      S_TRACE_CHK: begin
        v_raddr = v_r;
        if (depth_r == '0 && v_rdata.cost == DIST_INF) begin
          state_nxt = S_EMIT_UNR;
        end else begin
          s_we      = 1'b1;
          depth_nxt = depth_p1;
          if (v_r == src_r || v_rdata.parent[VIDX_W] || depth_p1 == n_active) begin
            cnt_nxt   = depth_p1;
            state_nxt = S_EMIT_RD;
          end else begin
            v_nxt     = v_rdata.parent[VIDX_W-1:0];
            state_nxt = S_TRACE_RD;
          end
        end
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (out_free) begin
          res.ld          = 1'b1;
          res.vertex      = s_rdata[STACK_W-1 -: VIDX_W];
          res.distance    = s_rdata[OUT_DIST_W-1:0];
          res.unreachable = 1'b0;
          res.last        = (cnt_r == VCNT_W'(1));
          if (cnt_r == VCNT_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = cnt_m1;
            state_nxt = S_EMIT_RD;
          end
        end
      end
      S_EMIT_UNR: begin
        if (out_free) begin
          res.ld          = 1'b1;
          res.vertex      = dst_r;
          res.distance    = DIST_INF[OUT_DIST_W-1:0];
          res.unreachable = 1'b1;
          res.last        = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
    cnt_r   <= cnt_nxt;
    round_r <= round_nxt;
    src_r   <= src_nxt;
    dst_r   <= dst_nxt;
    u_r     <= u_nxt;
    best_r  <= best_nxt;
    v_r     <= v_nxt;
    depth_r <= depth_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/core/dsp_checker.sv
// port-level checks for the shortest path block, bound to its top level
// depends on dsp_pkg
`default_nettype none
module dsp_checker
  import dsp_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [OUT_DIST_W-1:0] out_path_distance,
  input wire logic                  out_unreachable,
  input wire logic                  out_last
);

  // reset starts the matrix sweep, so no item is taken right after it
  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_unr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_unreachable |-> out_last && out_path_distance == '1)
    else $error("unreachable beat not final or not infinite");

  a_reach: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_unreachable |-> out_path_distance != '1)
    else $error("path beat carries infinite distance");

endmodule

bind dense_dijkstra_shortest_path dsp_checker u_dsp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_path_distance (out_path_distance),
  .out_unreachable   (out_unreachable),
  .out_last          (out_last)
);
`default_nettype wire
